/* rtl/core/wdt_pkg.sv */
// ----------------------------------------------------------------------------
// wdt_pkg
// shared constants and types of the wigner delta table generator
// ----------------------------------------------------------------------------
package wdt_pkg;

  // default bounds of the top level parameters
  localparam int DEF_MAX_DEGREE_BOUND = 255;
  localparam int DEF_VALUE_WIDTH      = 40;

  // coefficient format and long division length
  localparam int COEF_FRAC = 31;
  localparam int COEF_W    = 32;
  localparam int DIV_STEPS = 62;

  // one queued tick from the front part to the back part
  typedef struct packed {
    logic restart;
  } wdt_item_t;

endpackage

/* rtl/core/wdt_ram.sv */
// ----------------------------------------------------------------------------
// wdt_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wdt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/wdt_front.sv */
// ----------------------------------------------------------------------------
// wdt_front
// input side: takes ticks and queues them for the back part (two entries)
// ----------------------------------------------------------------------------
module wdt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               restart,
  output logic               full,
  output logic               item_valid,
  output wdt_pkg::wdt_item_t item,
  input  logic               item_take
);
  import wdt_pkg::*;

  wdt_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr].restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/wdt_sqrt_ratio.sv */
// ----------------------------------------------------------------------------
// wdt_sqrt_ratio
// iterative sqrt(num/den) in unsigned q1.31: 62-step long division, bit-serial root
// ----------------------------------------------------------------------------
module wdt_sqrt_ratio #(
  parameter int NW = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NW-1:0]              num,
  input  logic [NW-1:0]              den,
  output logic                       done,
  output logic [wdt_pkg::COEF_W-1:0] coef
);
  import wdt_pkg::*;

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_DIV   = 2'd1;
  localparam logic [1:0] C_SQRT  = 2'd2;
  localparam logic [1:0] C_ROUND = 2'd3;

  logic [1:0]    state;
  logic [NW-1:0] dreg;
  logic [NW:0]   drem;
  logic [63:0]   quo;
  logic [5:0]    cnt;
  logic [63:0]   srem;
  logic [63:0]   sres;
  logic [63:0]   sbit;
  logic [NW:0]   dshift;
  logic [63:0]   strial;

  assign dshift = {drem[NW-1:0], 1'b0};
  assign strial = sres + sbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            if (den == '0) begin
              coef <= '0;
              done <= 1'b1;
            end else if (num >= den) begin
              coef <= COEF_W'(1) << COEF_FRAC;
              done <= 1'b1;
            end else begin
              dreg  <= den;
              drem  <= {1'b0, num};
              quo   <= '0;
              cnt   <= 6'(DIV_STEPS - 1);
              state <= C_DIV;
            end
          end
        end
        C_DIV: begin
          if (dshift >= {1'b0, dreg}) begin
            drem <= dshift - {1'b0, dreg};
            quo  <= {quo[62:0], 1'b1};
          end else begin
            drem <= dshift;
            quo  <= {quo[62:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= C_SQRT;
            sres  <= '0;
            sbit  <= 64'(1) << 62;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        C_SQRT: begin
          if (sbit == (64'(1) << 62)) begin
            // first step works on the finished quotient
            if (quo >= sbit) begin
              srem <= quo - sbit;
              sres <= sbit;
            end else begin
              srem <= quo;
              sres <= '0;
            end
          end else if (srem >= strial) begin
            srem <= srem - strial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit == 64'd1) begin
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          // round to nearest: bump when remainder exceeds root
          if (srem > sres) begin
            coef <= sres[COEF_W-1:0] + COEF_W'(1);
          end else begin
            coef <= sres[COEF_W-1:0];
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/wdt_coef_mul.sv */
// ----------------------------------------------------------------------------
// wdt_coef_mul
// shift-add value times coefficient, round half away from zero, saturate
// ----------------------------------------------------------------------------
module wdt_coef_mul #(
  parameter int VW = 40,
  parameter int CW = 41
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [VW-1:0] x,
  input  logic [CW-1:0]        c,
  output logic                 done,
  output logic signed [VW-1:0] prod
);
  import wdt_pkg::*;

  localparam int PW  = VW + CW;
  localparam int MGW = PW + 1 - COEF_FRAC;
  localparam int SW  = $clog2(CW + 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIN  = 2'd2;

  localparam logic [MGW-1:0] HALF = MGW'(1) << (VW - 1);
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic [1:0]    state;
  logic [VW-1:0] mag;
  logic          neg;
  logic [CW-1:0] creg;
  logic [PW-1:0] acc;
  logic [SW-1:0] cnt;
  logic [PW:0]   rsum;
  logic [MGW-1:0] mg;

  assign rsum = {1'b0, acc} + ((PW+1)'(1) << (COEF_FRAC - 1));
  assign mg   = rsum[PW:COEF_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            neg   <= x[VW-1];
            mag   <= x[VW-1] ? VW'(-x) : VW'(x);
            creg  <= c;
            acc   <= '0;
            cnt   <= SW'(CW);
            state <= M_RUN;
          end
        end
        M_RUN: begin
          acc  <= (acc << 1) + (creg[CW-1] ? PW'(mag) : '0);
          creg <= creg << 1;
          cnt  <= cnt - SW'(1);
          if (cnt == SW'(1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          if (neg) begin
            prod <= (mg >= HALF) ? VMIN : -$signed(mg[VW-1:0]);
          end else begin
            prod <= (mg > HALF - MGW'(1)) ? VMAX : $signed(mg[VW-1:0]);
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/wdt_back.sv */
// ----------------------------------------------------------------------------
// wdt_back
// recursion sequencer: walks the table, drives the coefficient and multiply
// units, keeps the top row store and the result register
// ----------------------------------------------------------------------------
module wdt_back #(
  parameter int MAX_DEGREE_BOUND = wdt_pkg::DEF_MAX_DEGREE_BOUND,
  parameter int VALUE_WIDTH      = wdt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    max_degree,
  input  logic                          item_valid,
  input  wdt_pkg::wdt_item_t            item,
  output logic                          item_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    degree,
  output logic [7:0]                    row_index,
  output logic [7:0]                    column_index,
  output logic signed [VALUE_WIDTH-1:0] element_value,
  output logic                          table_end
);
  import wdt_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int DW = $clog2(MAX_DEGREE_BOUND + 1);
  localparam int NW = 2 * DW + 3;
  localparam int CW = DW + 1 + COEF_W;
  localparam int LW = (DW > 8) ? DW : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_DCOEF = 4'd2;
  localparam logic [3:0] S_DMUL  = 4'd3;
  localparam logic [3:0] S_ACOEF = 4'd4;
  localparam logic [3:0] S_AMUL  = 4'd5;
  localparam logic [3:0] S_BCOEF = 4'd6;
  localparam logic [3:0] S_BMUL  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE  = VW'(1) << (VW - 2);

  logic [3:0]           state;
  logic [DW-1:0]        deg, col, row;
  logic                 gen_done;
  logic signed [VW-1:0] one_above, two_above, held, va, vres;
  logic [NW-1:0]        p_reg;

  logic                 coef_start, coef_done;
  logic [NW-1:0]        coef_num, coef_den;
  logic [COEF_W-1:0]    coef;
  logic                 mul_start, mul_done;
  logic signed [VW-1:0] mul_x, mul_prod;
  logic [CW-1:0]        mul_c;

  logic                 ram_we, ram_re;
  logic signed [VW-1:0] ram_rdata;

  logic                 is_diag, last_row, row_end, fin_deg;
  logic [LW-1:0]        limit;
  logic [NW-1:0]        l_n, c_n, r_n;
  logic [LW-1:0]        deg_x, row_x, col_x;
  logic                 out_free;

  function automatic logic signed [VW-1:0] sat_neg(input logic signed [VW-1:0] v);
    sat_neg = (v == VMIN) ? VMAX : -v;
  endfunction

  function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] d;
    d = {a[VW-1], a} - {b[VW-1], b};
    if (d[VW] != d[VW-1]) begin
      sat_sub = d[VW] ? VMIN : VMAX;
    end else begin
      sat_sub = d[VW-1:0];
    end
  endfunction

  assign l_n      = NW'(deg);
  assign c_n      = NW'(col);
  assign r_n      = NW'(row);
  assign is_diag  = (row == deg);
  assign last_row = ((r_n + NW'(1)) == l_n);
  assign row_end  = (row == '0) && (col == deg);
  assign limit    = (LW'(max_degree) > LW'(MAX_DEGREE_BOUND)) ? LW'(MAX_DEGREE_BOUND)
                                                             : LW'(max_degree);
  assign fin_deg  = (LW'(deg) >= limit);
  assign out_free = empty || pop;

  assign item_take = (state == S_IDLE) && item_valid;
  assign ram_re    = (state == S_SETUP);
  assign ram_we    = (state == S_OUT) && out_free && is_diag;

  wdt_ram #(.WIDTH(VW), .DEPTH(MAX_DEGREE_BOUND + 1), .AW(DW)) u_top_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col),
    .wdata (vres),
    .re    (ram_re),
    .raddr (col),
    .rdata (ram_rdata)
  );

  wdt_sqrt_ratio #(.NW(NW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (coef_start),
    .num   (coef_num),
    .den   (coef_den),
    .done  (coef_done),
    .coef  (coef)
  );

  wdt_coef_mul #(.VW(VW), .CW(CW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .c     (mul_c),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      deg        <= '0;
      col        <= '0;
      row        <= '0;
      gen_done   <= 1'b1;
      one_above  <= '0;
      two_above  <= '0;
      held       <= '0;
      coef_start <= 1'b0;
      mul_start  <= 1'b0;
      empty      <= 1'b1;
    end else begin
      coef_start <= 1'b0;
      mul_start  <= 1'b0;
      if (pop && !empty) begin
        empty <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.restart) begin
              deg      <= '0;
              col      <= '0;
              row      <= '0;
              gen_done <= 1'b0;
              state    <= S_SETUP;
            end else if (!gen_done) begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (deg == '0) begin
            vres  <= ONE;
            state <= S_OUT;
          end else if (is_diag) begin
            // diagonal: scale the previous degree's top row entry
            if (col == '0) begin
              coef_num <= (l_n << 1) - NW'(1);
              coef_den <= l_n << 1;
            end else begin
              coef_num <= l_n * ((l_n << 1) - NW'(1));
              coef_den <= ((l_n + c_n) * (l_n + c_n - NW'(1))) << 1;
            end
            coef_start <= 1'b1;
            state      <= S_DCOEF;
          end else begin
            p_reg      <= (l_n - r_n) * (l_n + r_n + NW'(1));
            coef_num   <= NW'(1);
            coef_den   <= (l_n - r_n) * (l_n + r_n + NW'(1));
            coef_start <= 1'b1;
            state      <= S_ACOEF;
          end
        end
        S_DCOEF: begin
          if (coef_done) begin
            mul_x     <= (col == '0) ? ram_rdata : held;
            mul_c     <= CW'(coef);
            mul_start <= 1'b1;
            state     <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_done) begin
            vres  <= (col == '0) ? sat_neg(mul_prod) : mul_prod;
            state <= S_OUT;
          end
        end
        S_ACOEF: begin
          if (coef_done) begin
            mul_x     <= one_above;
            mul_c     <= CW'(coef) * CW'({col, 1'b0});
            mul_start <= 1'b1;
            state     <= S_AMUL;
          end
        end
        S_AMUL: begin
          if (mul_done) begin
            if (last_row) begin
              vres  <= mul_prod;
              state <= S_OUT;
            end else begin
              va         <= mul_prod;
              coef_num   <= (l_n - r_n - NW'(1)) * (l_n + r_n + NW'(2));
              coef_den   <= p_reg;
              coef_start <= 1'b1;
              state      <= S_BCOEF;
            end
          end
        end
        S_BCOEF: begin
          if (coef_done) begin
            mul_x     <= two_above;
            mul_c     <= CW'(coef);
            mul_start <= 1'b1;
            state     <= S_BMUL;
          end
        end
        S_BMUL: begin
          if (mul_done) begin
            vres  <= sat_sub(va, mul_prod);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            empty         <= 1'b0;
            degree        <= deg_x[7:0];
            row_index     <= row_x[7:0];
            column_index  <= col_x[7:0];
            element_value <= vres;
            table_end     <= row_end && fin_deg;
            if (is_diag) begin
              if (col < deg) begin
                held <= ram_rdata;
              end
              one_above <= vres;
              two_above <= '0;
            end else begin
              two_above <= one_above;
              one_above <= vres;
            end
            // advance to the next element
            if (row_end) begin
              if (fin_deg) begin
                gen_done <= 1'b1;
              end else begin
                deg <= deg + DW'(1);
                col <= '0;
                row <= deg + DW'(1);
              end
            end else if (row == '0) begin
              col <= col + DW'(1);
              row <= deg;
            end else begin
              row <= row - DW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign deg_x = LW'(deg);
  assign row_x = LW'(row);
  assign col_x = LW'(col);

endmodule

/* rtl/core/wigner_delta_table_generator.sv */
// ----------------------------------------------------------------------------
// wigner_delta_table_generator
// wigner delta (pi/2 rotation) element generator in signed q1.(w-2)
// ----------------------------------------------------------------------------
// latency per tick, from front queue to result, depends on its kind: an idle
//   tick does no work, degree zero is direct, a diagonal entry or the first
//   row below the diagonal needs one coefficient and one multiply, other rows
//   two of each; it is set by the shared division/root unit and the shift-add
//   multiplier (CW = 33 + bits of the degree bound, 41 by default)
// throughput: one tick at a time in the back part; the two-entry front queue
//   and the result register let each side stall on its own
// reset: queue and result empty, generation stopped until a restart tick,
//   max_degree zero; the top row store is not cleared
// ----------------------------------------------------------------------------
module wigner_delta_table_generator #(
  parameter int MAX_DEGREE_BOUND = wdt_pkg::DEF_MAX_DEGREE_BOUND,
  parameter int VALUE_WIDTH      = wdt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration register
  input  logic                          max_degree_we,
  input  logic [7:0]                    max_degree_wdata,
  // tick channel
  input  logic                          push,
  output logic                          full,
  input  logic                          restart,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    degree,
  output logic [7:0]                    row_index,
  output logic [7:0]                    column_index,
  output logic signed [VALUE_WIDTH-1:0] element_value,
  output logic                          table_end
);
  import wdt_pkg::*;

  logic       [7:0] max_degree;
  logic             item_valid;
  logic             item_take;
  wdt_item_t        item;

  // highest degree, read each time a degree finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_degree <= '0;
    end else if (max_degree_we) begin
      max_degree <= max_degree_wdata;
    end
  end

  // front: queue each tick transaction
  wdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .restart    (restart),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back: recursion sequencer with its arithmetic units and result register
  wdt_back #(
    .MAX_DEGREE_BOUND (MAX_DEGREE_BOUND),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .max_degree    (max_degree),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .empty         (empty),
    .pop           (pop),
    .degree        (degree),
    .row_index     (row_index),
    .column_index  (column_index),
    .element_value (element_value),
    .table_end     (table_end)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wigner delta table generator: directed table
// rows, then random tick streams over several max_degree settings; each popped
// element is checked against a fixed answer or an in-bench recursion predictor
// ----------------------------------------------------------------------------
module tb;

  import wdt_pkg::*;

  localparam int VW = DEF_VALUE_WIDTH;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam logic signed [VW-1:0] ONE = 1 <<< (VW - 2);
  // quiet wait after draining, with margin over the slowest tick
  localparam int QUIET_CYCLES = 400;

  typedef struct {
    logic [7:0]          deg;
    logic [7:0]          row;
    logic [7:0]          col;
    logic signed [VW-1:0] val;
    logic                last;
  } element_t;

  // one row of the directed table: either a register write or a tick
  typedef struct {
    bit         cfg;
    logic [7:0] cfg_val;
    bit         rs;
    bit         typed;
    bit         typed_some;
    logic signed [VW-1:0] val;
    bit         last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic max_degree_we = 1'b0;
  logic [7:0] max_degree_wdata = '0;
  logic push = 1'b0;
  logic restart = 1'b0;
  logic pop = 1'b0;
  logic full, empty, table_end;
  logic [7:0] degree, row_index, column_index;
  logic signed [VW-1:0] element_value;

  // predictor state, mirrors the recursion bookkeeping
  logic [7:0] deg_limit;
  longint     top_row [0:255];
  longint     held_entry, one_above, two_above;
  int         deg_cnt, col_cnt, row_cnt;
  bit         gen_done;

  element_t   pending_elements [$];
  int         fail_count = 0;
  bit         sender_busy_mode = 1'b1;
  bit         receiver_busy_mode = 1'b1;

  always #6 clk = ~clk;

  wigner_delta_table_generator DUT (
    .clk             (clk),
    .rst             (rst),
    .max_degree_we   (max_degree_we),
    .max_degree_wdata(max_degree_wdata),
    .push            (push),
    .full            (full),
    .restart         (restart),
    .empty           (empty),
    .pop             (pop),
    .degree          (degree),
    .row_index       (row_index),
    .column_index    (column_index),
    .element_value   (element_value),
    .table_end       (table_end)
  );

  // ---------------------------------------------------------------- arithmetic

  // integer square root, rounded to nearest
  function automatic logic [63:0] round_isqrt(logic [63:0] q);
    logic [63:0] rem, res, b;
    rem = q;
    res = 0;
    b = 64'h1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (q - res * res > res) res = res + 1;
    return res;
  endfunction

  // sqrt(n/d) in unsigned q1.31, by 62-step long division then root
  function automatic logic [63:0] ratio_root(logic [63:0] n, logic [63:0] d);
    logic [63:0] r, q;
    r = n;
    q = 0;
    if (d == 0) return 0;
    if (n >= d) return 64'h1 << COEF_FRAC;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return round_isqrt(q);
  endfunction

  // value times coefficient, rounded half away from zero, saturated
  function automatic longint scale_value(longint x, logic [63:0] c);
    logic [127:0] p;
    logic [63:0]  m, mag;
    bit           neg;
    neg = x < 0;
    m = neg ? 64'(-x) : 64'(x);
    p = {64'b0, m} * {64'b0, c};
    p = p + (128'h1 << (COEF_FRAC - 1));
    mag = (p[127:64+COEF_FRAC] != 0) ? '1 : p[63+COEF_FRAC:COEF_FRAC];
    if (neg) begin
      if (mag >= 64'(VMAX) + 1) return VMIN;
      return -longint'(mag);
    end
    if (mag > 64'(VMAX)) return VMAX;
    return longint'(mag);
  endfunction

  function automatic longint clamp_value(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // advance the recursion by one tick; returns 1 when an element comes out
  function automatic bit delta_next_element(bit rs, output element_t e);
    longint v, old;
    longint l, c, r, p, a, b;
    bit last;
    last = 1'b0;
    e = '{default: '0};
    if (rs) begin
      deg_cnt = 0;
      col_cnt = 0;
      row_cnt = 0;
      gen_done = 1'b0;
    end
    if (gen_done) return 1'b0;
    l = deg_cnt;
    c = col_cnt;
    r = row_cnt;
    if (l == 0) begin
      v = 64'sd1 <<< (VW - 2);
      top_row[0] = v;
      one_above = v;
      two_above = 0;
    end else if (r == l) begin
      // diagonal element, built from the previous degree's top row
      if (c == 0) begin
        old = top_row[0];
        v = scale_value(old, ratio_root(2 * l - 1, 2 * l));
        v = (v == VMIN) ? VMAX : -v;
      end else begin
        old = held_entry;
        v = scale_value(old, ratio_root(l * (2 * l - 1), 2 * (l + c) * (l + c - 1)));
      end
      if (c < l) held_entry = top_row[c];
      top_row[c] = v;
      one_above = v;
      two_above = 0;
    end else begin
      p = (l - r) * (l + r + 1);
      a = 2 * c * longint'(ratio_root(1, p));
      v = scale_value(one_above, a);
      if (r + 1 != l) begin
        b = longint'(ratio_root((l - r - 1) * (l + r + 2), p));
        v = clamp_value(v - scale_value(two_above, b));
      end
      two_above = one_above;
      one_above = v;
    end
    e.deg = l[7:0];
    e.row = r[7:0];
    e.col = c[7:0];
    e.val = v[VW-1:0];
    if (r == 0 && c == l) begin
      if (l >= deg_limit) begin
        last = 1'b1;
        gen_done = 1'b1;
      end else begin
        deg_cnt = l + 1;
        col_cnt = 0;
        row_cnt = l + 1;
      end
    end else if (r == 0) begin
      col_cnt = c + 1;
      row_cnt = l;
    end else begin
      row_cnt = r - 1;
    end
    e.last = last;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving

  // one tick transaction; entered and left at a falling edge
  task automatic send_tick(bit rs, bit typed, bit typed_some, element_t typed_e);
    int       gap;
    bit       some;
    element_t e;
    gap = sender_busy_mode ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge
    some = delta_next_element(rs, e);
    if (typed) begin
      some = typed_some;
      e = typed_e;
    end
    if (some) pending_elements.push_back(e);
    @(negedge clk);
  endtask

  // wait until every expected element has popped and the block has gone quiet
  task automatic drain_quiet();
    push <= 1'b0;
    wait (pending_elements.size() == 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_degree(logic [7:0] value);
    drain_quiet();
    max_degree_we <= 1'b1;
    max_degree_wdata <= value;
    @(negedge clk);
    max_degree_we <= 1'b0;
    deg_limit = value;
  endtask

  // ---------------------------------------------------------------- checking

  initial begin : result_side
    int       stall;
    element_t exp_e;
    @(negedge clk);
    wait (!rst);
    forever begin
      stall = receiver_busy_mode ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      // one result transaction at this edge
      if (pending_elements.size() == 0) begin
        $error("unexpected element l=%0d m1=%0d m2=%0d", degree, row_index, column_index);
        fail_count++;
      end else begin
        exp_e = pending_elements.pop_front();
        if (degree !== exp_e.deg) begin
          $error("degree: expected %0d, got %0d", exp_e.deg, degree);
          fail_count++;
        end
        if (row_index !== exp_e.row) begin
          $error("row_index: expected %0d, got %0d", exp_e.row, row_index);
          fail_count++;
        end
        if (column_index !== exp_e.col) begin
          $error("column_index: expected %0d, got %0d", exp_e.col, column_index);
          fail_count++;
        end
        if (element_value !== exp_e.val) begin
          $error("element_value: expected %0d, got %0d", exp_e.val, element_value);
          fail_count++;
        end
        if (table_end !== exp_e.last) begin
          $error("table_end: expected %0d, got %0d", exp_e.last, table_end);
          fail_count++;
        end
      end
      if ($urandom_range(0, 31) == 0) receiver_busy_mode = !receiver_busy_mode;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    dir_row_t   dir_rows [24];
    element_t   typed_e;
    logic [7:0] phase_limits [7];
    int         n_items;
    bit         rs;

    // reset values of the predictor
    deg_limit = 0;
    foreach (top_row[i]) top_row[i] = 0;
    held_entry = 0;
    one_above = 0;
    two_above = 0;
    deg_cnt = 0;
    col_cnt = 0;
    row_cnt = 0;
    gen_done = 1'b1;

    // directed table: fixed answers only where obvious (idle ticks, degree zero)
    dir_rows = '{
      '{0, 0,   0, 1, 0, 0,   0},  // tick right after reset: idle
      '{0, 0,   1, 1, 1, ONE, 1},  // restart with max_degree zero: lone 1.0
      '{0, 0,   0, 1, 0, 0,   0},  // finished table yields nothing
      '{1, 2,   0, 0, 0, 0,   0},
      '{0, 0,   1, 1, 1, ONE, 0},  // degree zero no longer ends the table
      '{0, 0,   0, 0, 0, 0,   0},  // degree one: diagonal at column zero
      '{0, 0,   0, 0, 0, 0,   0},  // first row below the diagonal
      '{0, 0,   0, 0, 0, 0,   0},  // diagonal from the held top row entry
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},  // degree two
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},  // full three-term row
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},
      '{0, 0,   0, 0, 0, 0,   0},  // last element of degree two, table end
      '{0, 0,   0, 1, 0, 0,   0},
      '{0, 0,   1, 1, 1, ONE, 0},  // restart, then stop mid-table
      '{0, 0,   0, 0, 0, 0,   0},
      '{1, 255, 0, 0, 0, 0,   0},  // largest degree setting
      '{0, 0,   1, 1, 1, ONE, 0},
      '{0, 0,   0, 0, 0, 0,   0}
    };
    phase_limits = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd6, 8'd2, 8'd128};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_max_degree(dir_rows[i].cfg_val);
      end else begin
        typed_e = '{8'd0, 8'd0, 8'd0, dir_rows[i].val, dir_rows[i].last};
        send_tick(dir_rows[i].rs, dir_rows[i].typed, dir_rows[i].typed_some, typed_e);
      end
    end

    // random phases, each under its own max_degree
    foreach (phase_limits[ph]) begin
      write_max_degree(phase_limits[ph]);
      n_items = 110;
      for (int k = 0; k < n_items; k++) begin
        rs = (k == 0) || ($urandom_range(0, 39) == 0);
        if (ph == 1 && k == 50) begin
          // sender holds off until the pipe is empty
          drain_quiet();
        end
        if ($urandom_range(0, 19) == 0) sender_busy_mode = !sender_busy_mode;
        send_tick(rs, 1'b0, 1'b0, typed_e);
      end
    end

    push <= 1'b0;
    wait (pending_elements.size() == 0);
    repeat (QUIET_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_elements.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #(40_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
